// File: rtl/zero_run_length_encoder_top_assert.svh
// Assertion macros used by the checker of the zero run-length encoder.
`ifndef ZERO_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH
`define ZERO_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ZRLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ZRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ZRLE_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/zrle_pkg.sv
// Types and constants shared by the zero run-length encoder modules.
`default_nettype none
package zrle_pkg;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [7:0] MARKER_BYTE = 8'h00;
  localparam logic [7:0] SAT_BYTE    = 8'hFF;

  // What one input transaction asks the back to emit, in this order:
  // a saturated run, a closing run, then a literal.
  typedef struct packed {
    logic       run1;
    logic       run2;
    logic       lit;
    logic       last;
    logic [7:0] lit_byte;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/zrle_queue.sv
// Small command queue that decouples the front classifier from the back sequencer.
`default_nettype none
module zrle_queue #(
  parameter int CW = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire zrle_pkg::cmd_t  push_cmd,
  input  wire logic [CW-1:0]   push_cnt,
  input  wire logic            pop,
  output zrle_pkg::cmd_t       head_cmd,
  output logic [CW-1:0]        head_cnt,
  output logic                 empty,
  output logic                 full
);

  zrle_pkg::cmd_t                 cmd_mem_r [zrle_pkg::QDEPTH];
  logic [CW-1:0]                  cnt_mem_r [zrle_pkg::QDEPTH];
  logic [zrle_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [zrle_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [zrle_pkg::QCNT_W-1:0]    fill_r, fill_nxt;
  logic                           do_push, do_pop;

  assign empty    = (fill_r == '0);
  assign full     = (fill_r == zrle_pkg::QCNT_W'(zrle_pkg::QDEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = cmd_mem_r[rd_ptr_r];
  assign head_cnt = cnt_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_mem_r[wr_ptr_r] <= push_cmd;
      cnt_mem_r[wr_ptr_r] <= push_cnt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/zrle_front.sv
// Front stage: tracks the open zero run and turns each input byte into a command.
`default_nettype none
module zrle_front #(
  parameter int COUNT_BYTES = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [7:0]                in_byte,
  input  wire logic                      in_block_end,
  output logic                           cmd_push,
  output zrle_pkg::cmd_t                 cmd,
  output logic [8*COUNT_BYTES-1:0]       cmd_cnt
);

  localparam int CW = 8 * COUNT_BYTES;

  logic          run_open_r, run_open_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cnt_new;
  logic          is_zero;

  assign is_zero = (in_byte == 8'h00);

  always_comb begin
    cmd          = '0;
    cmd.lit_byte = in_byte;
    cmd.last     = in_block_end;
    cmd_cnt      = cnt_r;
    cnt_new      = '0;
    run_open_nxt = run_open_r;
    cnt_nxt      = cnt_r;
    if (is_zero) begin
      if (!run_open_r) begin
        cnt_new = '0;
      end else if (cnt_r == '1) begin
        // The count is saturated: close this run and let this zero open a new one.
        cmd.run1 = 1'b1;
        cnt_new  = '0;
      end else begin
        cnt_new = cnt_r + 1'b1;
      end
      if (in_block_end) begin
        cmd.run2     = 1'b1;
        cmd_cnt      = cnt_new;
        run_open_nxt = 1'b0;
        cnt_nxt      = '0;
      end else begin
        run_open_nxt = 1'b1;
        cnt_nxt      = cnt_new;
      end
    end else begin
      cmd.run2     = run_open_r;
      cmd.lit      = 1'b1;
      run_open_nxt = 1'b0;
      cnt_nxt      = '0;
    end
  end

  assign cmd_push = accept && (cmd.run1 || cmd.run2 || cmd.lit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r <= 1'b0;
      cnt_r      <= '0;
    end else if (accept) begin
      run_open_r <= run_open_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/zrle_back.sv
// Back stage: turns queued commands into encoded bytes in the output reg, one per unstalled cycle.
`default_nettype none
module zrle_back #(
  parameter int COUNT_BYTES = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire zrle_pkg::cmd_t            head_cmd,
  input  wire logic [8*COUNT_BYTES-1:0]  head_cnt,
  input  wire logic                      q_empty,
  output logic                           q_pop,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [7:0]                     out_byte,
  output logic                           out_final_byte
);

  localparam int CW    = 8 * COUNT_BYTES;
  localparam int IDX_W = $clog2(COUNT_BYTES + 1);

  logic             busy_r;
  logic             r1_r, r2_r, lit_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CW-1:0]    sh_r, sh_nxt;
  logic             out_valid_r;
  logic [7:0]       out_byte_r, byte_nxt;
  logic             out_final_r;

  logic r1, r2, lit;
  logic seg_run1, seg_run2, seg_lit;
  logic seg_done, emit, advance;
  logic r1_n, r2_n, lit_n, cmd_done;

  assign advance = !out_valid_r || pop;
  assign emit    = advance && (busy_r || !q_empty);

  assign r1  = busy_r ? r1_r  : head_cmd.run1;
  assign r2  = busy_r ? r2_r  : head_cmd.run2;
  assign lit = busy_r ? lit_r : head_cmd.lit;

  assign seg_run1 = r1;
  assign seg_run2 = !r1 && r2;
  assign seg_lit  = !r1 && !r2;
  assign seg_done = seg_lit || (idx_r == IDX_W'(COUNT_BYTES));

  assign r1_n     = r1 && !(seg_run1 && seg_done);
  assign r2_n     = r2 && !(seg_run2 && seg_done);
  assign lit_n    = lit && !seg_lit;
  assign cmd_done = !(r1_n || r2_n || lit_n);
  assign q_pop    = emit && cmd_done;

  always_comb begin
    sh_nxt = sh_r;
    if (seg_lit) begin
      byte_nxt = head_cmd.lit_byte;
      idx_nxt  = '0;
    end else begin
      if (idx_r == '0) begin
        byte_nxt = zrle_pkg::MARKER_BYTE;
      end else if (seg_run1) begin
        byte_nxt = zrle_pkg::SAT_BYTE;
      end else begin
        byte_nxt = sh_r[CW-1 -: 8];
      end
      idx_nxt = seg_done ? '0 : idx_r + 1'b1;
      if (seg_run2) begin
        sh_nxt = (idx_r == '0) ? head_cnt : (sh_r << 8);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      r1_r        <= 1'b0;
      r2_r        <= 1'b0;
      lit_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        busy_r <= !cmd_done;
        r1_r   <= r1_n;
        r2_r   <= r2_n;
        lit_r  <= lit_n;
        idx_r  <= idx_nxt;
      end
      if (advance) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sh_r        <= sh_nxt;
      out_byte_r  <= byte_nxt;
      out_final_r <= head_cmd.last && cmd_done;
    end
  end

  assign empty          = !out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_final_byte = out_final_r;

endmodule
`default_nettype wire

// File: rtl/zero_run_length_encoder_top.sv
// Top level of the zero run-length encoder: front classifier, command queue and back sequencer.
//
// The encoder takes one source byte per transaction on a queue-style input
// (push/full) and delivers encoded bytes on a queue-style output (empty/pop).
// Nonzero bytes pass through as literals. A run of zeros is held open and
// emitted when it closes, on the next nonzero byte or at the end of the block,
// as a zero marker byte followed by COUNT_BYTES big-endian bytes counting the
// zeros after the first. If that count would overflow, the run is closed at
// the all-ones count and a new run starts, so no zero is lost. The last
// encoded byte of a block has out_final_byte set. The front classifies each
// accepted input transaction and writes any command it makes into a
// four-entry queue; the back expands commands at one encoded byte per cycle
// into an output register whenever the output is not stalled. Literals thus
// stream at one byte per cycle under the same condition; a closed run yields
// 1 + COUNT_BYTES output bytes (twice that when a saturated run closes too).
// A command keeps its queue entry until its last byte is emitted, so while
// the back drains a run the queue takes up to three further commands before
// full rises. Once full is high every input transaction waits, including
// zeros that only extend an open run and make no command. When the output
// side is idle and the queue is empty, the first encoded byte of an input
// transaction passes a queue entry and the output register before the ports.
`default_nettype none
module zero_run_length_encoder_top #(
  parameter int COUNT_BYTES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_block_end,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_final_byte
);

  localparam int CW = 8 * COUNT_BYTES;

  logic           accept;
  logic           cmd_push;
  zrle_pkg::cmd_t cmd;
  logic [CW-1:0]  cmd_cnt;
  zrle_pkg::cmd_t head_cmd;
  logic [CW-1:0]  head_cnt;
  logic           q_empty, q_full, q_pop;

  // The input side stalls only when the command queue has no room.
  assign full   = q_full;
  assign accept = push && !q_full;

  zrle_front #(.COUNT_BYTES(COUNT_BYTES)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_block_end (in_block_end),
    .cmd_push     (cmd_push),
    .cmd          (cmd),
    .cmd_cnt      (cmd_cnt)
  );

  zrle_queue #(.CW(CW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .push_cnt (cmd_cnt),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .head_cnt (head_cnt),
    .empty    (q_empty),
    .full     (q_full)
  );

  zrle_back #(.COUNT_BYTES(COUNT_BYTES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_cmd       (head_cmd),
    .head_cnt       (head_cnt),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_final_byte (out_final_byte)
  );

endmodule
`default_nettype wire

// File: rtl/zrle_checker.sv
// Port-level checker for the zero run-length encoder and its bind to the top level.
`default_nettype none
`include "zero_run_length_encoder_top_assert.svh"
module zrle_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       push,
  input wire logic       full,
  input wire logic [7:0] in_byte,
  input wire logic       in_block_end,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_final_byte
);

  // Reset leaves no result pending and the input side open.
  `ZRLE_ASSERT_RST(a_reset_idle, !rst_n, empty && !full, "encoder not idle after reset")

  // A waiting result that is not taken stays and holds its value.
  `ZRLE_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_final_byte), "result changed while stalled")

  // Every shown result carries known bits.
  `ZRLE_ASSERT_NOW(a_out_known, !empty, !$isunknown(out_byte) && !$isunknown(out_final_byte), "unknown bits on a shown result")

  // An accepted transaction never carries unknown payload into the encoder.
  `ZRLE_ASSERT_NOW(a_in_known, push && !full, !$isunknown(in_byte) && !$isunknown(in_block_end), "unknown bits on an accepted input")

endmodule

bind zero_run_length_encoder_top zrle_checker u_zrle_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .in_byte        (in_byte),
  .in_block_end   (in_block_end),
  .empty          (empty),
  .pop            (pop),
  .out_byte       (out_byte),
  .out_final_byte (out_final_byte)
);
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the zero run-length encoder: random and directed byte blocks.
module testbench;

  // The block runs with its default four count bytes.
  localparam int CNT_BYTES = 4;
  localparam int RANDOM_ITEMS = 350;
  localparam int IDLE_PCT = 18;

  // Predicts the encoded byte stream and checks each popped byte against it.
  class zrle_scoreboard #(int CB = 4);
    typedef struct packed {
      logic [7:0] data;
      logic       fin;
    } enc_t;

    bit              run_open;
    logic [8*CB-1:0] extra_zeros;
    enc_t            step_out[$];
    enc_t            awaited[$];
    int unsigned     errors;

    function new();
      run_open = 1'b0;
      extra_zeros = '0;
      errors = 0;
    endfunction

    // A closed run is the marker followed by the count, most significant byte first.
    function void put_run(logic [8*CB-1:0] cnt);
      step_out.push_back('{zrle_pkg::MARKER_BYTE, 1'b0});
      for (int k = CB - 1; k >= 0; k--) begin
        step_out.push_back('{cnt[8*k +: 8], 1'b0});
      end
    endfunction

    function void note_input(logic [7:0] b, logic last);
      step_out.delete();
      if (b == 8'h00) begin
        if (!run_open) begin
          run_open = 1'b1;
          extra_zeros = '0;
        end else if (extra_zeros == '1) begin
          // The count cannot grow: close at the maximum and open a new run.
          put_run('1);
          extra_zeros = '0;
        end else begin
          extra_zeros++;
        end
        if (last) begin
          put_run(extra_zeros);
        end
      end else begin
        if (run_open) begin
          put_run(extra_zeros);
        end
        step_out.push_back('{b, 1'b0});
      end
      // A literal closes any run, and a block end clears everything.
      if (last || b != 8'h00) begin
        run_open = 1'b0;
        extra_zeros = '0;
      end
      if (last) begin
        step_out[step_out.size() - 1].fin = 1'b1;
      end
      foreach (step_out[i]) begin
        awaited.push_back(step_out[i]);
      end
    endfunction

    function void check_result(logic [7:0] data, logic fin);
      enc_t want;
      if (awaited.size() == 0) begin
        $error("unexpected encoded byte: out_byte %02h out_final_byte %0b", data, fin);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, data);
        errors++;
      end
      if (fin !== want.fin) begin
        $error("out_final_byte: expected %0b, actual %0b", want.fin, fin);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_block_end = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_final_byte;

  zrle_scoreboard #(CNT_BYTES) sb;
  int unsigned items_sent = 0;

  zero_run_length_encoder_top #(
    .COUNT_BYTES(CNT_BYTES)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .in_block_end(in_block_end),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .out_final_byte(out_final_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both channels are observed at the rising edge, where the values read are
  // those that stood before the edge. The input transaction is noted before
  // the output one, although an item never produces output in its own cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        sb.note_input(in_byte, in_block_end);
      end
      if (pop && !empty) begin
        sb.check_result(out_byte, out_final_byte);
      end
    end
  end

  // Offers one byte and returns at the edge that accepts it. The push stays
  // high for a following byte unless a random gap is taken; items 150 to 259
  // are sent back to back.
  task automatic send_byte(input logic [7:0] b, input logic last);
    push <= 1'b1;
    in_byte <= b;
    in_block_end <= last;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    items_sent++;
    if (!(items_sent >= 150 && items_sent < 260) && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // A run of zeros; the block end, if asked for, falls on the last zero.
  task automatic send_zero_run(input int unsigned len, input logic end_on_last);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'h00, end_on_last && i == len - 1);
    end
  endtask

  // One well-formed block: runs of zeros mixed with literals, the last byte
  // carrying the block end. Now and then a run is long enough for the second
  // least significant count byte to be nonzero.
  task automatic send_random_block();
    logic [7:0] blk[$];
    int unsigned segs;
    segs = $urandom_range(1, 8);
    for (int s = 0; s < segs; s++) begin
      if ($urandom_range(0, 99) < 40) begin
        repeat (($urandom_range(0, 59) == 0) ? $urandom_range(257, 300) : $urandom_range(1, 5))
          blk.push_back(8'h00);
      end else begin
        repeat ($urandom_range(1, 4)) blk.push_back(8'($urandom_range(1, 255)));
      end
    end
    foreach (blk[i]) begin
      send_byte(blk[i], i == blk.size() - 1);
    end
  endtask

  // The receiver pops at random, with a stretch of no idling and two long
  // hold-offs during which the sender keeps pushing until the block fills.
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      rx_cycle++;
      if ((rx_cycle >= 120 && rx_cycle < 200) || (rx_cycle >= 380 && rx_cycle < 440)) begin
        pop <= 1'b0;
      end else if (rx_cycle >= 220 && rx_cycle < 360) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
      @(posedge clk);
    end
  end

  initial begin
    #50_000_000;
    $display("[zero_run_length_encoder_top] ERROR");
    $finish;
  end

  initial begin
    int unsigned start_items;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: literal extremes, a lone zero ending a block, runs
    // closed by a literal and by a block end, and a literal ending a block
    // while a run is open.
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b1);
    send_zero_run(3, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);

    // Random part: mostly well-formed blocks, some single bytes with a
    // random block end as noise.
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        send_random_block();
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    // Any byte that shows up after the last expected one is caught here.
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[zero_run_length_encoder_top] OK");
    end else begin
      $display("[zero_run_length_encoder_top] ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/zrle_pkg.sv
rtl/zrle_queue.sv
rtl/zrle_front.sv
rtl/zrle_back.sv
rtl/zero_run_length_encoder_top.sv
rtl/zrle_checker.sv
tb/testbench.sv
